FILE: rtl/bresenham_line_rasterizer_macros.svh
// Assertion macros for the line rasterizer RTL.
// Depends on clk_i and rst_ni being present in the including module.
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BLR_ASSERT_NOW(lbl, ante, cons, msg)
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/blr_pkg.sv
// Shared types and constants of the line rasterizer.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS = 6;
  // Decision value range is about +/- 2^(COORD_BITS+1); one sign bit on top.
  localparam int DW         = COORD_BITS + 3;
  localparam int QDEPTH     = 2;
  localparam int QAW        = 1;
  localparam int QCW        = 2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } blr_req_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } blr_pix_t;

  // Classified line: ordered start point, major/minor lengths, directions.
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t dl;
    coord_t ds;
    logic   major_y;
    logic   y_neg;
  } blr_line_t;

  // Queue status seen by the stepper.
  typedef struct packed {
    logic valid;
  } blr_qctl_t;

endpackage

`default_nettype wire

FILE: rtl/blr_front.sv
// Front end: accepts line requests, orders endpoints and picks the major axis.
// Depends on blr_pkg.
`default_nettype none

module blr_front import blr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire blr_req_t  req_i,
  output logic           busy,
  input  wire logic      q_full_i,
  output logic           push_o,
  output blr_line_t      line_o
);

  logic      vld_q, vld_d;
  blr_line_t line_q;
  blr_line_t line_d;
  logic      accept;
  logic      swap;
  coord_t    xa, ya, xb, yb, dx, ady;
  logic      dy_neg;

  always_comb begin
    swap   = (req_i.x_end < req_i.x_start) ||
             ((req_i.x_end == req_i.x_start) && (req_i.y_end < req_i.y_start));
    xa     = swap ? req_i.x_end   : req_i.x_start;
    ya     = swap ? req_i.y_end   : req_i.y_start;
    xb     = swap ? req_i.x_start : req_i.x_end;
    yb     = swap ? req_i.y_start : req_i.y_end;
    dx     = xb - xa;
    dy_neg = yb < ya;
    ady    = dy_neg ? (ya - yb) : (yb - ya);

    line_d.x0      = xa;
    line_d.y0      = ya;
    line_d.major_y = (ady >= dx);
    line_d.dl      = line_d.major_y ? ady : dx;
    line_d.ds      = line_d.major_y ? dx  : ady;
    line_d.y_neg   = dy_neg;
  end

  assign push_o = vld_q && !q_full_i;
  assign busy   = vld_q && q_full_i;
  assign accept = start && !busy;
  assign line_o = line_q;

  assign vld_d = accept || (vld_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q <= line_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/blr_queue.sv
// Two-entry queue of classified lines between front end and stepper.
// Depends on blr_pkg and the assertion macro header.
`default_nettype none
`include "bresenham_line_rasterizer_macros.svh"

module blr_queue import blr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire blr_line_t line_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output blr_line_t      line_o
);

  blr_line_t          mem_q [QDEPTH];
  logic [QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]     cnt_q, cnt_d;
  logic               do_pop;

  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign line_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= line_i;
    end
  end

  `BLR_ASSERT_NOW(a_no_overflow, push_i, !full_o, "push into full queue")
  `BLR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCW'(QDEPTH), "queue count beyond depth")
  `BLR_ASSERT_NEXT(a_cnt_grow, push_i && !do_pop, cnt_q == $past(cnt_q) + QCW'(1), "count stuck")

endmodule

`default_nettype wire

FILE: rtl/blr_back.sv
// Back end: steps one queued line a pixel per cycle by the Bresenham rule.
// Depends on blr_pkg and the assertion macro header.
`default_nettype none
`include "bresenham_line_rasterizer_macros.svh"

module blr_back import blr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire blr_qctl_t qctl_i,
  output logic           pop_o,
  input  wire blr_line_t line_i,
  output logic           pix_valid_o,
  output blr_pix_t       pix_o
);

  logic                  active_q;
  logic                  load;
  logic                  last;
  coord_t                x_q, y_q, rem_q, dl_q, ds_q;
  logic                  major_y_q, y_neg_q;
  logic signed [DW-1:0]  d_q, d_sub, d_n;
  logic signed [DW-1:0]  ds2, dl2;
  logic                  min_step, step_x, step_y;
  logic                  out_vld_q;
  blr_pix_t              pix_q;

  assign last  = (rem_q == '0);
  assign load  = qctl_i.valid && (!active_q || last);
  assign pop_o = load;

  always_comb begin
    ds2      = signed'({2'b00, ds_q, 1'b0});
    dl2      = signed'({2'b00, dl_q, 1'b0});
    d_sub    = d_q - ds2;
    min_step = d_sub[DW-1];
    d_n      = min_step ? (d_sub + dl2) : d_sub;
    step_x   = major_y_q ? min_step : 1'b1;
    step_y   = major_y_q ? 1'b1 : min_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= active_q;
      if (load) begin
        active_q <= 1'b1;
      end else if (active_q && last) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (active_q) begin
      pix_q.pixel_x    <= x_q;
      pix_q.pixel_y    <= y_q;
      pix_q.last_pixel <= last;
    end
    if (load) begin
      x_q       <= line_i.x0;
      y_q       <= line_i.y0;
      dl_q      <= line_i.dl;
      ds_q      <= line_i.ds;
      rem_q     <= line_i.dl;
      major_y_q <= line_i.major_y;
      y_neg_q   <= line_i.y_neg;
      d_q       <= signed'({3'b000, line_i.dl});
    end else if (active_q) begin
      d_q   <= d_n;
      rem_q <= rem_q - COORD_BITS'(1);
      if (step_x) begin
        x_q <= x_q + COORD_BITS'(1);
      end
      if (step_y) begin
        y_q <= y_neg_q ? (y_q - COORD_BITS'(1)) : (y_q + COORD_BITS'(1));
      end
    end
  end

  assign pix_valid_o = out_vld_q;
  assign pix_o       = pix_q;

  `BLR_ASSERT_NEXT(a_active_emits, active_q, out_vld_q, "active cycle without pixel")
  `BLR_ASSERT_NOW(a_mid_line_active, out_vld_q && !pix_q.last_pixel, active_q, "line ended early")
  `BLR_ASSERT_NEXT(a_load_starts, load, active_q && (rem_q == $past(line_i.dl)), "load lost")

endmodule

`default_nettype wire

FILE: rtl/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
// Depends on blr_pkg, blr_front, blr_queue and blr_back.
//
// Usage:
//   Request channel: drive req_i with two endpoints and raise start; the
//   request transfers at a rising edge where start is high and busy is low.
//   Busy rises only when the front register holds a line and the two-entry
//   queue behind it is full.
//   Pixel channel: each pixel appears on pix_o for exactly one cycle with
//   pix_valid_o high; last_pixel marks the final pixel of a line. The
//   receiver cannot stall, so every strobed pixel is a completed transfer.
// Path: when the stepper is idle, the first pixel of a line passes the front
//   register, the queue, the stepper load and the output register, in that
//   order, after its request transfers.
// Throughput: a line of L = max(|dx|,|dy|) + 1 pixels holds the stepper while
//   its L pixels leave, one pixel per cycle; the stepper loads the next queued line in
//   the cycle of the last pixel, so lines follow without a gap. The single
//   stepper sets the sustained rate; the longest line has 64 pixels.
// Reset: rst_ni clears the front register, the queue and the stepper; no
//   pixel is strobed until a request has transferred.
`default_nettype none

module bresenham_line_rasterizer import blr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire blr_req_t req_i,
  output logic          busy,
  output logic          pix_valid_o,
  output blr_pix_t      pix_o
);

  // Front end to queue.
  logic      push;
  logic      q_full;
  blr_line_t front_line;

  // Queue to stepper.
  blr_qctl_t qctl;
  logic      q_valid;
  logic      q_pop;
  blr_line_t q_line;

  blr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .req_i    (req_i),
    .busy     (busy),
    .q_full_i (q_full),
    .push_o   (push),
    .line_o   (front_line)
  );

  blr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .line_i  (front_line),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .line_o  (q_line)
  );

  // Bundle the queue status for the stepper.
  assign qctl.valid = q_valid;

  blr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qctl_i      (qctl),
    .pop_o       (q_pop),
    .line_i      (q_line),
    .pix_valid_o (pix_valid_o),
    .pix_o       (pix_o)
  );

endmodule

`default_nettype wire

FILE: dv/bresenham_line_rasterizer_tb.sv
// Self-checking testbench for bresenham_line_rasterizer.
// Depends on blr_pkg for the request and pixel structs and on the RTL of the block.
// A directed list of lines and then random lines, checked pixel by pixel against a local tracer.

module bresenham_line_rasterizer_tb import blr_pkg::*; ();

  localparam int CMAX        = (1 << COORD_BITS) - 1;
  localparam int RAND_LINES  = 396;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk_i = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  blr_req_t req_d = '0;
  logic     busy;
  logic     pix_valid;
  blr_pix_t pix;

  // Lines waiting to be driven, and pixels traced but not yet seen.
  blr_req_t line_q[$];
  blr_pix_t pixel_q[$];

  int total_lines;
  int lines_sent;
  int pixels_seen;
  int err_cnt;
  int cycles;
  int n_single, n_xmajor, n_ymajor, n_diag, longest;

  bresenham_line_rasterizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .start      (start),
    .req_i      (req_d),
    .busy       (busy),
    .pix_valid_o(pix_valid),
    .pix_o      (pix)
  );

  always #1 clk_i = ~clk_i;

  function automatic blr_req_t make_req(int xs, int ys, int xe, int ye);
    blr_req_t r;
    r.x_start = coord_t'(xs);
    r.y_start = coord_t'(ys);
    r.x_end   = coord_t'(xe);
    r.y_end   = coord_t'(ye);
    return r;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > CMAX) ? CMAX : v);
  endfunction

  // Trace one line and append its pixels, in drawing order, to pixel_q.
  function automatic void trace_line(blr_req_t r);
    int xa, ya, xb, yb, dx, dy, adx, ady;
    int majx, majy, minx, miny, dl, ds, dv;
    blr_pix_t p;
    xa = int'(r.x_start);
    ya = int'(r.y_start);
    xb = int'(r.x_end);
    yb = int'(r.y_end);
    dx = xb - xa;
    dy = yb - ya;
    // Normalize: leftward lines, or vertical lines going down, start at the far end.
    if (dx < 0 || (dx == 0 && dy < 0)) begin
      xa = xb;
      ya = yb;
      dx = -dx;
      dy = -dy;
    end
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    // Ties go to the y axis.
    if (adx > ady) begin
      majx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      majy = 0;
      minx = 0;
      miny = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      dl   = adx;
      ds   = ady;
      n_xmajor++;
    end else begin
      majx = 0;
      majy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      minx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      miny = 0;
      dl   = ady;
      ds   = adx;
      n_ymajor++;
    end
    if (dl == 0) n_single++;
    if (dl != 0 && adx == ady) n_diag++;
    if (dl + 1 > longest) longest = dl + 1;
    dv = dl;
    for (int k = 0; k <= dl; k++) begin
      if (k > 0) begin
        dv -= 2 * ds;
        if (dv < 0) begin
          dv += 2 * dl;
          xa += minx;
          ya += miny;
        end
        xa += majx;
        ya += majy;
      end
      p.pixel_x    = coord_t'(xa);
      p.pixel_y    = coord_t'(ya);
      p.last_pixel = (k == dl);
      pixel_q.push_back(p);
    end
  endfunction

  // Request driver: hold a request until it transfers, idle at random between
  // requests. The idle rate steps from 18 to 82 percent, then to none.
  always @(posedge clk_i) begin : drive_proc
    int  idle_pct;
    bit  free;
    if (rst_n) begin
      free = 1'b1;
      if (start) begin
        if (!busy) begin
          // Transfer on this edge: trace the line and retire it.
          trace_line(req_d);
          void'(line_q.pop_front());
          lines_sent++;
        end else begin
          // Hold the request while the block is full.
          free = 1'b0;
        end
      end
      if (free) begin
        if (lines_sent < total_lines / 3) idle_pct = 18;
        else if (lines_sent < (2 * total_lines) / 3) idle_pct = 82;
        else idle_pct = 0;
        if (line_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          req_d <= line_q[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: every strobe is a completed transfer; compare it with the
  // oldest traced pixel.
  always @(posedge clk_i) begin : watch_proc
    blr_pix_t want;
    if (rst_n && pix_valid) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        $error("pixel (%0d,%0d) last=%0b strobed with none outstanding",
               pix.pixel_x, pix.pixel_y, pix.last_pixel);
        err_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (pix.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, pix.pixel_x);
          err_cnt++;
        end
        if (pix.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, pix.pixel_y);
          err_cnt++;
        end
        if (pix.last_pixel !== want.last_pixel) begin
          $error("last_pixel: expected %0b, got %0b", want.last_pixel, pix.last_pixel);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: give up far beyond the slowest correct run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lines sent, %0d pixels outstanding",
               cycles, lines_sent, pixel_q.size());
      $display("bresenham_line_rasterizer_tb: done, errors");
      $finish;
    end
  end

  initial begin : stim_proc
    int xs, ys, xe, ye, sx, sy, room_x, room_y, len;
    // Directed lines: single points, both axes both ways, exact diagonals,
    // one-step minors, two-pixel lines and the far corners.
    line_q.push_back(make_req(0, 0, 0, 0));
    line_q.push_back(make_req(CMAX, CMAX, CMAX, CMAX));
    line_q.push_back(make_req(0, 0, CMAX, 0));
    line_q.push_back(make_req(CMAX, 5, 0, 5));
    line_q.push_back(make_req(10, 0, 10, CMAX));
    line_q.push_back(make_req(20, CMAX, 20, 0));
    line_q.push_back(make_req(0, 0, CMAX, CMAX));
    line_q.push_back(make_req(CMAX, CMAX, 0, 0));
    line_q.push_back(make_req(0, CMAX, CMAX, 0));
    line_q.push_back(make_req(CMAX, 0, 0, CMAX));
    line_q.push_back(make_req(0, 0, CMAX, 1));
    line_q.push_back(make_req(0, 0, 1, CMAX));
    line_q.push_back(make_req(CMAX, 0, 0, 1));
    line_q.push_back(make_req(1, CMAX, 0, 0));
    line_q.push_back(make_req(5, 40, 30, 10));
    line_q.push_back(make_req(30, 10, 5, 40));
    line_q.push_back(make_req(12, 3, 17, 60));
    line_q.push_back(make_req(17, 60, 12, 3));
    line_q.push_back(make_req(0, 0, 1, 0));
    line_q.push_back(make_req(0, 1, 0, 0));
    line_q.push_back(make_req(42, 21, 21, 42));
    line_q.push_back(make_req(0, 0, 2, 1));
    line_q.push_back(make_req(CMAX, 0, CMAX - 1, CMAX));
    line_q.push_back(make_req(0, CMAX, CMAX, CMAX - 1));

    // Random lines: half with free endpoints, plus short lines, axis-aligned
    // lines, exact diagonals and single points.
    for (int i = 0; i < RAND_LINES; i++) begin
      xs = $urandom_range(0, CMAX);
      ys = $urandom_range(0, CMAX);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          xe = $urandom_range(0, CMAX);
          ye = $urandom_range(0, CMAX);
        end
        5, 6: begin
          xe = clamp_coord(xs + int'($urandom_range(0, 8)) - 4);
          ye = clamp_coord(ys + int'($urandom_range(0, 8)) - 4);
        end
        7: begin
          if ($urandom_range(0, 1)) begin
            xe = xs;
            ye = $urandom_range(0, CMAX);
          end else begin
            xe = $urandom_range(0, CMAX);
            ye = ys;
          end
        end
        8: begin
          sx     = $urandom_range(0, 1) ? 1 : -1;
          sy     = $urandom_range(0, 1) ? 1 : -1;
          room_x = (sx > 0) ? CMAX - xs : xs;
          room_y = (sy > 0) ? CMAX - ys : ys;
          len    = $urandom_range(0, (room_x < room_y) ? room_x : room_y);
          xe     = xs + sx * len;
          ye     = ys + sy * len;
        end
        default: begin
          xe = xs;
          ye = ys;
        end
      endcase
      line_q.push_back(make_req(xs, ys, xe, ye));
    end
    total_lines = line_q.size();

    // Hold reset, then release it once for the whole run.
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    // Wait for every line to transfer, then for every traced pixel.
    while (line_q.size() > 0) @(posedge clk_i);
    while (pixel_q.size() > 0) @(posedge clk_i);
    // Allow a few more cycles so stray pixels get caught.
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pixel_q.size() > 0) begin
      $error("%0d traced pixels never strobed", pixel_q.size());
      err_cnt++;
    end

    $display("run covered %0d lines and %0d pixels in %0d cycles, longest line %0d pixels",
             lines_sent, pixels_seen, cycles, longest);
    $display("line mix: %0d x-major, %0d y-major, %0d exact diagonals, %0d single points",
             n_xmajor, n_ymajor, n_diag, n_single);
    if (err_cnt == 0) begin
      $display("bresenham_line_rasterizer_tb: done, clean");
    end else begin
      $display("bresenham_line_rasterizer_tb: done, errors");
    end
    $finish;
  end

endmodule
